@@ rtl/core/ais_pkg.sv @@
// ----------------------------------------------------------------------------
// ais_pkg: shared types and constants of the array set
// Capacity, field structs, status codes and cell control bundle.
// ----------------------------------------------------------------------------
package ais_pkg;

   localparam int CAPACITY  = 16;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int KEY_W     = 32;
   localparam int STATUS_W  = 3;
   localparam int RSP_CNT_W = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic                    opcode;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [RSP_CNT_W-1:0] count;
   } rsp_type;

   // control bundle seen by one cell during the execute cycle
   typedef struct packed {
      logic [KEY_W-1:0] key;     // key under search
      logic             active;  // cell holds a live entry
      logic             load;    // cell takes the new key
      logic             remove;  // remove request in progress
   } cell_ctl_type;

endpackage

@@ rtl/core/ais_cell.sv @@
// ----------------------------------------------------------------------------
// ais_cell: one storage cell of the array set
// Holds one key, compares it, extends the match chain and shifts down.
// ----------------------------------------------------------------------------
module ais_cell (
   input  logic                  clock,
   input  ais_pkg::cell_ctl_type ctl,
   input  logic                  hit_in,
   input  logic [31:0]           next_entry,
   output logic                  hit_out,
   output logic [31:0]           entry
);
   import ais_pkg::*;

   logic [KEY_W-1:0] entry_ff;
   logic [KEY_W-1:0] entry_in;
   logic             hit;

   assign hit     = ctl.active && (entry_ff == ctl.key);
   assign hit_out = hit_in | hit;
   assign entry   = entry_ff;

   // at or after the first match a remove pulls the upper neighbor down
   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = ctl.key;
      end else if (ctl.remove && hit_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ rtl/core/array_set_insert_remove_top.sv @@
// ----------------------------------------------------------------------------
// array_set_insert_remove_top: set of distinct 32-bit keys in a cell chain
// Insert appends an absent key, remove deletes a key and closes the gap.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request is
// registered first, then handled in the execute cycle, in which all cells compare the key
// at once, the match ripples along the cell chain and the entries shift or
// load. The result strobe rsp_valid is high for exactly one cycle, on the cycle
// after the execute cycle; it cannot be held off, so capture it when it comes.
// A new request may be started in the same cycle as that strobe; while busy is
// high no request is taken. Keys keep insertion order in the cells.
module array_set_insert_remove_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ais_pkg::req_type req_data,
   output logic             rsp_valid,
   output ais_pkg::rsp_type rsp_data
);
   import ais_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   // control state
   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;

   // cell chain wiring
   cell_ctl_type     ctl_w [CAPACITY];
   logic [CAPACITY:0] hit_w;
   logic [KEY_W-1:0] entry_w [CAPACITY];

   logic accept;
   logic exec;
   logic found;
   logic full;
   logic insert_ok;
   logic remove_ok;

   assign busy   = (state_ff == ST_EXEC);
   assign accept = start && !busy;
   assign exec   = (state_ff == ST_EXEC);

   // the chain end tells whether any live cell matched
   assign hit_w[0] = 1'b0;
   assign found    = hit_w[CAPACITY];
   assign full     = (count_ff == CNT_W'(CAPACITY));

   assign insert_ok = exec && (req_ff.opcode == OP_INSERT) && !found && !full;
   assign remove_ok = exec && (req_ff.opcode == OP_REMOVE) && found;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         // live cells are those below the count; the load target is the first free one
         assign ctl_w[gi].key    = req_ff.key;
         assign ctl_w[gi].active = exec && (CNT_W'(gi) < count_ff);
         assign ctl_w[gi].load   = insert_ok && (CNT_W'(gi) == count_ff);
         assign ctl_w[gi].remove = exec && (req_ff.opcode == OP_REMOVE);

         if (gi == CAPACITY - 1) begin : g_last
            ais_cell u_cell (
               .clock      (clock),
               .ctl        (ctl_w[gi]),
               .hit_in     (hit_w[gi]),
               .next_entry (entry_w[gi]),
               .hit_out    (hit_w[gi+1]),
               .entry      (entry_w[gi])
            );
         end else begin : g_mid
            ais_cell u_cell (
               .clock      (clock),
               .ctl        (ctl_w[gi]),
               .hit_in     (hit_w[gi]),
               .next_entry (entry_w[gi+1]),
               .hit_out    (hit_w[gi+1]),
               .entry      (entry_w[gi])
            );
         end
      end
   endgenerate

   // sequencing, count update and result formation
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      req_in       = req_ff;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (insert_ok) begin
               count_in = count_ff + CNT_W'(1);
            end else if (remove_ok) begin
               count_in = count_ff - CNT_W'(1);
            end
            // presence wins over fullness on insert
            if (req_ff.opcode == OP_INSERT) begin
               if (found) begin
                  rsp_in.status = ST_PRESENT;
               end else if (full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.status = ST_INSERTED;
               end
            end else begin
               rsp_in.status = found ? ST_REMOVED : ST_NOT_FOUND;
            end
            rsp_in.count = RSP_CNT_W'(count_in);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // an accepted transfer always moves into the execute cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not enter execute");

   // the cycle after execute is idle and carries the result strobe
   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("execute not followed by result");

   // the element count never exceeds the capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count beyond capacity");

   // a result only follows an execute cycle
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without request");

endmodule

@@ verif/ais_result_checker.sv @@
// ----------------------------------------------------------------------------
// ais_result_checker: scoreboard for the array set
// Watches request and result transfers, keeps a shadow copy of the held keys,
// and compares every result strobe against the oldest outcome still due.
// ----------------------------------------------------------------------------
module ais_result_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  ais_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  ais_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import ais_pkg::*;

   // int variables start at zero, the reset branch clears the shadow set
   logic [KEY_W-1:0] shadow_keys [CAPACITY];
   int               shadow_count;
   rsp_type          due_outcomes [$];

   // applies one request to the shadow set and gives the status and new count
   task automatic apply_to_set(input req_type r, output rsp_type o);
      int hit;
      hit = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (hit < 0 && shadow_keys[i] == r.key) begin
            hit = i;
         end
      end
      if (r.opcode == OP_INSERT) begin
         if (hit >= 0) begin
            o.status = ST_PRESENT;
         end else if (shadow_count >= CAPACITY) begin
            o.status = ST_FULL;
         end else begin
            shadow_keys[shadow_count] = r.key;
            shadow_count++;
            o.status = ST_INSERTED;
         end
      end else begin
         if (hit >= 0) begin
            for (int i = hit; i < shadow_count - 1; i++) begin
               shadow_keys[i] = shadow_keys[i + 1];
            end
            shadow_count--;
            o.status = ST_REMOVED;
         end else begin
            o.status = ST_NOT_FOUND;
         end
      end
      o.count = RSP_CNT_W'(shadow_count);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type next_due;
      if (reset) begin
         due_outcomes.delete();
         shadow_count = 0;
      end else begin
         // a result always comes after its request, so the strobe is checked before a new request is queued
         if (rsp_valid) begin
            if (due_outcomes.size() == 0) begin
               $display("%0t: unexpected result status=%0d count=%0d",
                        $time, rsp_data.status, rsp_data.count);
               fail_count++;
            end else begin
               want = due_outcomes.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status mismatch expected=%0d actual=%0d",
                           $time, want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.count !== want.count) begin
                  $display("%0t: count mismatch expected=%0d actual=%0d",
                           $time, want.count, rsp_data.count);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            apply_to_set(req_data, next_due);
            due_outcomes.push_back(next_due);
         end
      end
      pending = due_outcomes.size();
   end

endmodule

@@ verif/tb_array_set_insert_remove_top.sv @@
// ----------------------------------------------------------------------------
// tb_array_set_insert_remove_top: stimulus and verdict for the array set
// Directed inserts and removes over the edge cases, then bursts of random
// requests that sweep the set between empty and full; checking is done by
// the scoreboard instance beside the block.
// ----------------------------------------------------------------------------
module tb_array_set_insert_remove_top;
   import ais_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 700;
   localparam int HISTORY_MAX  = 40;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      cycles;

   // keys sent recently, so that removes and repeated inserts actually hit
   logic [KEY_W-1:0] recent_keys [$];

   array_set_insert_remove_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   ais_result_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // watchdog: a hung block or a lost result ends here (cycles starts at zero)
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // one request transfer: drive at the falling edge, hold until taken
   task automatic issue(input logic op, input logic [KEY_W-1:0] k);
      @(negedge clock);
      start        <= 1'b1;
      req_data     <= '{opcode: op, key: k};
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op == OP_INSERT) begin
         recent_keys.push_back(k);
         if (recent_keys.size() > HISTORY_MAX) void'(recent_keys.pop_front());
      end
   endtask

   // idle gap with start low, its length given by n
   task automatic hold_off(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // stop sending until every result due has come back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // fresh key, leaning on the two's complement extremes, zero and all ones now and then
   function automatic logic [KEY_W-1:0] fresh_key();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] recent_key();
      if (recent_keys.size() == 0) return fresh_key();
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
   endfunction

   initial begin
      int sent;
      int burst;
      int insert_pct;
      logic op;
      logic [KEY_W-1:0] k;

      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      issue(OP_REMOVE, 32'h0000_0005);   // remove from empty set
      issue(OP_INSERT, 32'h8000_0000);   // most negative key
      issue(OP_INSERT, 32'h7FFF_FFFF);   // most positive key
      issue(OP_INSERT, 32'h0000_0000);
      issue(OP_INSERT, 32'hFFFF_FFFF);
      issue(OP_INSERT, 32'h8000_0000);   // already present
      issue(OP_REMOVE, 32'h0000_0005);   // absent key
      issue(OP_REMOVE, 32'h0000_0000);   // middle entry, tail shifts down
      for (int i = 1; i <= 13; i++) begin
         issue(OP_INSERT, i * 32'h1111_1111);
      end
      issue(OP_INSERT, 32'h1234_5678);   // absent key into full set
      issue(OP_INSERT, 32'h7FFF_FFFF);   // held key in full set reports present
      issue(OP_REMOVE, 32'h8000_0000);   // first entry, everything shifts
      issue(OP_REMOVE, 32'hDDDD_DDDD);   // last entry

      drain();

      // --- random part: bursts, gaps, phases that fill and empty the set ---
      sent       = 0;
      insert_pct = 75;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 16);
         for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
            if ($urandom_range(0, 99) < insert_pct) begin
               op = OP_INSERT;
               k  = ($urandom_range(0, 2) == 0) ? recent_key() : fresh_key();
            end else begin
               op = OP_REMOVE;
               k  = ($urandom_range(0, 4) != 0) ? recent_key() : fresh_key();
            end
            issue(op, k);
            sent++;
            // swing between filling and emptying
            if (sent % 100 == 0) insert_pct = (insert_pct > 50) ? 30 : 75;
            if (sent % 150 == 0) drain();
         end
         // some bursts run straight into the next one
         if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
      end

      drain();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/ais_pkg.sv
rtl/core/ais_cell.sv
rtl/core/array_set_insert_remove_top.sv
verif/ais_result_checker.sv
verif/tb_array_set_insert_remove_top.sv
